// ===== rtl/tbb_pkg.sv =====
// ----------------------------------------------------------------------------
// tbb_pkg
// Shared types and constants for the transformed box bounds unit.
// ----------------------------------------------------------------------------
package tbb_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned HALF_W  = 31;
    localparam int unsigned PROD_W  = 2 * COORD_W;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned QPROD_W = PROD_W - FRAC_W;
    localparam int unsigned SUM_W   = QPROD_W + 2;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] mat_r0_c0;
        logic signed [COORD_W-1:0] mat_r0_c1;
        logic signed [COORD_W-1:0] mat_r0_c2;
        logic signed [COORD_W-1:0] mat_r0_c3;
        logic signed [COORD_W-1:0] mat_r1_c0;
        logic signed [COORD_W-1:0] mat_r1_c1;
        logic signed [COORD_W-1:0] mat_r1_c2;
        logic signed [COORD_W-1:0] mat_r1_c3;
        logic signed [COORD_W-1:0] mat_r2_c0;
        logic signed [COORD_W-1:0] mat_r2_c1;
        logic signed [COORD_W-1:0] mat_r2_c2;
        logic signed [COORD_W-1:0] mat_r2_c3;
    } t_mat_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_min_x;
        logic signed [COORD_W-1:0] world_min_y;
        logic signed [COORD_W-1:0] world_min_z;
        logic signed [COORD_W-1:0] world_max_x;
        logic signed [COORD_W-1:0] world_max_y;
        logic signed [COORD_W-1:0] world_max_z;
        logic        [HALF_W-1:0]  half_x;
        logic        [HALF_W-1:0]  half_y;
        logic        [HALF_W-1:0]  half_z;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
    } t_bounds_word;

    // load enables of the three row stages
    typedef struct packed {
        logic mul;
        logic sel;
        logic sum;
    } t_row_en;

endpackage

// ===== rtl/tbb_row.sv =====
// ----------------------------------------------------------------------------
// tbb_row
// One transform row: products with both padded corners, floor and per-column
// min/max selection, then the saturated sums of the minima and maxima.
// ----------------------------------------------------------------------------
module tbb_row import tbb_pkg::*; (
    input  logic                      i_clk,
    input  t_row_en                   i_en,
    input  logic signed [COORD_W-1:0] i_m [3],
    input  logic signed [COORD_W-1:0] i_t,
    input  logic signed [COORD_W-1:0] i_lo [3],
    input  logic signed [COORD_W-1:0] i_hi [3],
    output logic signed [COORD_W-1:0] o_min,
    output logic signed [COORD_W-1:0] o_max
);

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sd2147483648);

    logic signed [PROD_W-1:0]  r_plo [3];
    logic signed [PROD_W-1:0]  r_phi [3];
    logic signed [COORD_W-1:0] r_t1;
    logic signed [QPROD_W-1:0] r_qmin [3];
    logic signed [QPROD_W-1:0] r_qmax [3];
    logic signed [COORD_W-1:0] r_t2;
    logic signed [COORD_W-1:0] r_min;
    logic signed [COORD_W-1:0] r_max;

    logic signed [QPROD_W-1:0] n_qlo [3];
    logic signed [QPROD_W-1:0] n_qhi [3];
    logic signed [SUM_W-1:0]   n_smin;
    logic signed [SUM_W-1:0]   n_smax;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            for (int c = 0; c < 3; c++) begin
                r_plo[c] <= PROD_W'(i_m[c]) * PROD_W'(i_lo[c]);
                r_phi[c] <= PROD_W'(i_m[c]) * PROD_W'(i_hi[c]);
            end
            r_t1 <= i_t;
        end
    end

    // arithmetic shift right by the fraction width floors the product
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_qlo[c] = r_plo[c][PROD_W-1:FRAC_W];
            n_qhi[c] = r_phi[c][PROD_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sel) begin
            for (int c = 0; c < 3; c++) begin
                if (n_qlo[c] < n_qhi[c]) begin
                    r_qmin[c] <= n_qlo[c];
                    r_qmax[c] <= n_qhi[c];
                end else begin
                    r_qmin[c] <= n_qhi[c];
                    r_qmax[c] <= n_qlo[c];
                end
            end
            r_t2 <= r_t1;
        end
    end

    always_comb begin
        n_smin = SUM_W'(r_qmin[0]) + SUM_W'(r_qmin[1]) + SUM_W'(r_qmin[2]) + SUM_W'(r_t2);
        n_smax = SUM_W'(r_qmax[0]) + SUM_W'(r_qmax[1]) + SUM_W'(r_qmax[2]) + SUM_W'(r_t2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            if (n_smin > SAT_HI) begin
                r_min <= SAT_HI[COORD_W-1:0];
            end else if (n_smin < SAT_LO) begin
                r_min <= SAT_LO[COORD_W-1:0];
            end else begin
                r_min <= n_smin[COORD_W-1:0];
            end
            if (n_smax > SAT_HI) begin
                r_max <= SAT_HI[COORD_W-1:0];
            end else if (n_smax < SAT_LO) begin
                r_max <= SAT_LO[COORD_W-1:0];
            end else begin
                r_max <= n_smax[COORD_W-1:0];
            end
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

// ===== rtl/tbb_extent.sv =====
// ----------------------------------------------------------------------------
// tbb_extent
// Output stage: half extents and centres from the world bounds.
// ----------------------------------------------------------------------------
module tbb_extent import tbb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [COORD_W-1:0] i_min [3],
    input  logic signed [COORD_W-1:0] i_max [3],
    output t_bounds_word              o_word
);

    logic signed [COORD_W:0]   n_diff [3];
    logic        [HALF_W-1:0]  n_half [3];
    logic signed [COORD_W-1:0] n_ctr  [3];
    t_bounds_word              r_word;

    // max is never below min, so the difference is non-negative
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_diff[a] = (COORD_W+1)'(i_max[a]) - (COORD_W+1)'(i_min[a]);
            n_half[a] = n_diff[a][COORD_W-1:1];
            n_ctr[a]  = i_min[a] + $signed({1'b0, n_half[a]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word.world_min_x <= i_min[0];
            r_word.world_min_y <= i_min[1];
            r_word.world_min_z <= i_min[2];
            r_word.world_max_x <= i_max[0];
            r_word.world_max_y <= i_max[1];
            r_word.world_max_z <= i_max[2];
            r_word.half_x      <= n_half[0];
            r_word.half_y      <= n_half[1];
            r_word.half_z      <= n_half[2];
            r_word.center_x    <= n_ctr[0];
            r_word.center_y    <= n_ctr[1];
            r_word.center_z    <= n_ctr[2];
        end
    end

    assign o_word = r_word;

endmodule

// ===== rtl/transformed_box_bounds_unit.sv =====
// ----------------------------------------------------------------------------
// transformed_box_bounds_unit
// World-space bounds of a padded local box under an affine transform.
// ----------------------------------------------------------------------------
// Takes one transform word per clock while o_stall is low and returns its
// bounds word through registered stages: multiply, floor and select,
// saturated row sum, then half extents and centres in the output register.
// The first stage holds eighteen 32x32 multipliers. Box registers are padded
// by PAD_MARGIN as they are written, so a write affects the next word taken.
// ----------------------------------------------------------------------------
module transformed_box_bounds_unit import tbb_pkg::*; #(
    parameter int PAD_MARGIN = 655
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0] i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_mat_word          i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output t_bounds_word       o_word
);

    localparam logic signed [COORD_W:0] MARGIN = (COORD_W+1)'(PAD_MARGIN);
    localparam logic signed [COORD_W:0] C_HI   = (COORD_W+1)'(2147483647);
    localparam logic signed [COORD_W:0] C_LO   = -(COORD_W+1)'(64'sd2147483648);

    logic signed [COORD_W-1:0] r_lo [3];
    logic signed [COORD_W-1:0] r_hi [3];
    logic [3:0]                r_vld;

    logic signed [COORD_W:0]   n_dlo;
    logic signed [COORD_W:0]   n_dhi;
    logic signed [COORD_W-1:0] n_plo;
    logic signed [COORD_W-1:0] n_phi;
    logic [3:0]                n_rdy;
    t_row_en                   n_row_en;

    logic signed [COORD_W-1:0] n_m  [3][3];
    logic signed [COORD_W-1:0] n_t  [3];
    logic signed [COORD_W-1:0] n_wmin [3];
    logic signed [COORD_W-1:0] n_wmax [3];

    // padding with saturation, applied at write time
    always_comb begin
        n_dlo = $signed({i_cfg_data[COORD_W-1], i_cfg_data}) - MARGIN;
        n_dhi = $signed({i_cfg_data[COORD_W-1], i_cfg_data}) + MARGIN;
        if (n_dlo < C_LO) begin
            n_plo = C_LO[COORD_W-1:0];
        end else begin
            n_plo = n_dlo[COORD_W-1:0];
        end
        if (n_dhi > C_HI) begin
            n_phi = C_HI[COORD_W-1:0];
        end else begin
            n_phi = n_dhi[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= -COORD_W'(PAD_MARGIN);
                r_hi[a] <= COORD_W'(PAD_MARGIN);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_X: r_lo[0] <= n_plo;
                CFG_MIN_Y: r_lo[1] <= n_plo;
                CFG_MIN_Z: r_lo[2] <= n_plo;
                CFG_MAX_X: r_hi[0] <= n_phi;
                CFG_MAX_Y: r_hi[1] <= n_phi;
                CFG_MAX_Z: r_hi[2] <= n_phi;
                default: ;
            endcase
        end
    end

    // stage k loads when empty or when its successor loads
    always_comb begin
        n_rdy[3] = !r_vld[3] || !i_stall;
        n_rdy[2] = !r_vld[2] || n_rdy[3];
        n_rdy[1] = !r_vld[1] || n_rdy[2];
        n_rdy[0] = !r_vld[0] || n_rdy[1];
        n_row_en.mul = n_rdy[0];
        n_row_en.sel = n_rdy[1];
        n_row_en.sum = n_rdy[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) r_vld[0] <= i_valid;
            if (n_rdy[1]) r_vld[1] <= r_vld[0];
            if (n_rdy[2]) r_vld[2] <= r_vld[1];
            if (n_rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    assign o_stall = !n_rdy[0];
    assign o_valid = r_vld[3];

    always_comb begin
        n_m[0][0] = i_word.mat_r0_c0;
        n_m[0][1] = i_word.mat_r0_c1;
        n_m[0][2] = i_word.mat_r0_c2;
        n_t[0]    = i_word.mat_r0_c3;
        n_m[1][0] = i_word.mat_r1_c0;
        n_m[1][1] = i_word.mat_r1_c1;
        n_m[1][2] = i_word.mat_r1_c2;
        n_t[1]    = i_word.mat_r1_c3;
        n_m[2][0] = i_word.mat_r2_c0;
        n_m[2][1] = i_word.mat_r2_c1;
        n_m[2][2] = i_word.mat_r2_c2;
        n_t[2]    = i_word.mat_r2_c3;
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        tbb_row u_row (
            .i_clk (i_clk),
            .i_en  (n_row_en),
            .i_m   (n_m[r]),
            .i_t   (n_t[r]),
            .i_lo  (r_lo),
            .i_hi  (r_hi),
            .o_min (n_wmin[r]),
            .o_max (n_wmax[r])
        );
    end

    tbb_extent u_extent (
        .i_clk  (i_clk),
        .i_en   (n_rdy[3]),
        .i_min  (n_wmin),
        .i_max  (n_wmax),
        .o_word (o_word)
    );

endmodule
